>>> rtl/assert_macros.svh
// assertion macros shared by the frame buffer scanner rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// checked only outside reset
`define ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// checked at every edge, reset included
`define ASSERT_NOW(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ASSERT_RST(lbl, prop, msg)
`define ASSERT_NOW(lbl, prop, msg)

`endif

`endif

>>> rtl/lcfb_pkg.sv
// shared types, codes and constants of the frame buffer scanner
`default_nettype none

package lcfb_pkg;

	localparam int COORD_W     = 3;
	localparam int ACTION_W    = 3;
	localparam int KIND_W      = 2;
	localparam int ROW_W       = 8;
	localparam int FRAME_DEPTH = 64;
	localparam int FRAME_AW    = 6;
	localparam int QUEUE_DEPTH = 2;
	localparam int S_TDATA_W   = 16;
	localparam int M_TDATA_W   = 32;

	localparam logic [COORD_W-1:0] COORD_MAX = 3'd7;

	// input action codes
	localparam logic [ACTION_W-1:0] ACT_SET       = 3'd0;
	localparam logic [ACTION_W-1:0] ACT_CLR       = 3'd1;
	localparam logic [ACTION_W-1:0] ACT_READ      = 3'd2;
	localparam logic [ACTION_W-1:0] ACT_CLEAR_ALL = 3'd3;
	localparam logic [ACTION_W-1:0] ACT_FILL_ALL  = 3'd4;
	localparam logic [ACTION_W-1:0] ACT_ROTATE    = 3'd5;
	localparam logic [ACTION_W-1:0] ACT_REFRESH   = 3'd6;

	// result kinds
	localparam logic [KIND_W-1:0] KIND_ACK   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_LATCH = 2'd1;
	localparam logic [KIND_W-1:0] KIND_LAYER = 2'd2;

	typedef enum logic [2:0] {
		OP_SET,
		OP_CLR,
		OP_READ,
		OP_CLEAR_ALL,
		OP_FILL_ALL,
		OP_ROTATE,
		OP_REFRESH,
		OP_NOP
	} op_t;

	typedef struct packed {
		op_t                op;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] z;
	} cmd_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_EXEC,
		B_LAYER
	} back_state_t;

	// fixed column latch strobes, in latch order
	function automatic logic [ROW_W-1:0] latch_strobe(input logic [COORD_W-1:0] idx);
		logic [ROW_W-1:0] s;
		case (idx)
			3'd0:    s = 8'h01;
			3'd1:    s = 8'h02;
			3'd2:    s = 8'h04;
			3'd3:    s = 8'h08;
			3'd4:    s = 8'h80;
			3'd5:    s = 8'h40;
			3'd6:    s = 8'h20;
			3'd7:    s = 8'h10;
			default: s = 8'h00;
		endcase
		return s;
	endfunction

endpackage

`default_nettype wire

>>> rtl/lcfb_ram.sv
// generic single port ram with registered read
`default_nettype none

module lcfb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     en,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem[addr] <= wdata;
			end
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

>>> rtl/lcfb_front.sv
// front end: accepts action beats, decodes them and queues commands
`default_nettype none
`include "assert_macros.svh"

module lcfb_front
	import lcfb_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [S_TDATA_W-1:0] s_tdata,  // x [2:0], y [5:3], z [8:6], zero pad
	input  wire logic [ACTION_W-1:0]  s_tuser,  // action [2:0]
	output cmd_t                      head,
	output logic                      head_valid,
	input  wire logic                 head_pop
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	cmd_t             q_mem [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	cmd_t             dec;

	// classify the action code
	always_comb begin
		dec.x = s_tdata[2:0];
		dec.y = s_tdata[5:3];
		dec.z = s_tdata[8:6];
		case (s_tuser)
			ACT_SET:       dec.op = OP_SET;
			ACT_CLR:       dec.op = OP_CLR;
			ACT_READ:      dec.op = OP_READ;
			ACT_CLEAR_ALL: dec.op = OP_CLEAR_ALL;
			ACT_FILL_ALL:  dec.op = OP_FILL_ALL;
			ACT_ROTATE:    dec.op = OP_ROTATE;
			ACT_REFRESH:   dec.op = OP_REFRESH;
			default:       dec.op = OP_NOP;
		endcase
	end

	assign s_tready   = (count_q != CNT_W'(DEPTH));
	assign push       = s_tvalid && s_tready;
	assign head_valid = (count_q != '0);
	assign head       = q_mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_mem[wr_ptr_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (head_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, head_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	`ASSERT_RST(a_count_bound, count_q <= CNT_W'(DEPTH), "queue count exceeds depth")
	`ASSERT_RST(a_pop_nonempty, head_pop |-> head_valid, "pop from empty queue")
	`ASSERT_RST(a_pop_only, (head_pop && !push) |=> (count_q == $past(count_q) - 1'b1), "bad pop")

endmodule

`default_nettype wire

>>> rtl/lcfb_back.sv
// back end: frame memory, layer scan sequencer and output register
`default_nettype none
`include "assert_macros.svh"

module lcfb_back
	import lcfb_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire cmd_t                 head,
	input  wire logic                 head_valid,
	output logic                      head_pop,
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic      [M_TDATA_W-1:0] m_tdata,
	output logic      [KIND_W-1:0]    m_tuser,
	output logic                      m_tlast
);

	back_state_t state_q, state_d;

	op_t                 op_q;
	logic [COORD_W-1:0]  x_q;
	logic [FRAME_AW-1:0] addr_q;
	logic [COORD_W-1:0]  row_q;
	logic [COORD_W-1:0]  scan_q;
	logic [COORD_W-1:0]  off_q;
	logic                fill_q;
	logic [FRAME_DEPTH-1:0] valid_q;

	logic                m_valid_q;
	logic [M_TDATA_W-1:0] m_data_q;
	logic [KIND_W-1:0]   m_user_q;
	logic                m_last_q;

	logic                out_free;
	logic                ram_en;
	logic                ram_we;
	logic [FRAME_AW-1:0] ram_addr;
	logic [ROW_W-1:0]    ram_wdata;
	logic [ROW_W-1:0]    ram_rdata;
	logic [ROW_W-1:0]    cur_row;
	logic [ROW_W-1:0]    bit_mask;

	logic                load_cmd;
	logic                row_start;
	logic                row_next;
	logic                mark_valid;
	logic                wipe;
	logic                wipe_val;
	logic                rotate;
	logic                scan_adv;

	logic                emit;
	logic [KIND_W-1:0]   e_kind;
	logic [ROW_W-1:0]    e_row;
	logic [ROW_W-1:0]    e_latch;
	logic [ROW_W-1:0]    e_layer;
	logic                e_voxel;
	logic                e_last;

	lcfb_ram #(
		.WIDTH (ROW_W),
		.DEPTH (FRAME_DEPTH)
	) u_frame (
		.clk   (clk),
		.en    (ram_en),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	assign out_free = !m_valid_q || m_tready;
	// rows never written since reset or the last wipe read as fill_q, the wipe or reset value
	assign cur_row  = valid_q[addr_q] ? ram_rdata : {ROW_W{fill_q}};
	assign bit_mask = ROW_W'(1) << x_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			B_IDLE: begin
				if (head_valid && (head.op == OP_SET || head.op == OP_CLR ||
				    head.op == OP_READ || head.op == OP_REFRESH)) begin
					state_d = B_EXEC;
				end
			end
			B_EXEC: begin
				if (out_free) begin
					if (op_q == OP_REFRESH) begin
						state_d = (row_q == COORD_MAX) ? B_LAYER : B_EXEC;
					end else begin
						state_d = B_IDLE;
					end
				end
			end
			B_LAYER: begin
				if (out_free) begin
					state_d = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		head_pop   = 1'b0;
		ram_en     = 1'b0;
		ram_we     = 1'b0;
		ram_addr   = addr_q;
		ram_wdata  = cur_row;
		load_cmd   = 1'b0;
		row_start  = 1'b0;
		row_next   = 1'b0;
		mark_valid = 1'b0;
		wipe       = 1'b0;
		wipe_val   = 1'b0;
		rotate     = 1'b0;
		scan_adv   = 1'b0;
		emit       = 1'b0;
		e_kind     = KIND_ACK;
		e_row      = '0;
		e_latch    = '0;
		e_layer    = '0;
		e_voxel    = 1'b0;
		e_last     = 1'b0;
		case (state_q)
			B_IDLE: begin
				if (head_valid) begin
					case (head.op)
						OP_SET, OP_CLR, OP_READ: begin
							head_pop = 1'b1;
							load_cmd = 1'b1;
							ram_en   = 1'b1;
							ram_addr = {head.z + off_q, head.y};
						end
						OP_REFRESH: begin
							head_pop  = 1'b1;
							load_cmd  = 1'b1;
							row_start = 1'b1;
							ram_en    = 1'b1;
							ram_addr  = {scan_q + off_q, COORD_W'(0)};
						end
						default: begin
							if (out_free) begin
								head_pop = 1'b1;
								emit     = 1'b1;
								e_last   = 1'b1;
								wipe     = (head.op == OP_CLEAR_ALL) || (head.op == OP_FILL_ALL);
								wipe_val = (head.op == OP_FILL_ALL);
								rotate   = (head.op == OP_ROTATE);
							end
						end
					endcase
				end
			end
			B_EXEC: begin
				if (out_free) begin
					emit = 1'b1;
					case (op_q)
						OP_SET: begin
							ram_en     = 1'b1;
							ram_we     = 1'b1;
							ram_wdata  = cur_row | bit_mask;
							mark_valid = 1'b1;
							e_last     = 1'b1;
						end
						OP_CLR: begin
							ram_en     = 1'b1;
							ram_we     = 1'b1;
							ram_wdata  = cur_row & ~bit_mask;
							mark_valid = 1'b1;
							e_last     = 1'b1;
						end
						OP_READ: begin
							e_voxel = cur_row[x_q];
							e_last  = 1'b1;
						end
						OP_REFRESH: begin
							e_kind  = KIND_LATCH;
							e_row   = cur_row;
							e_latch = latch_strobe(row_q);
							// fetch the next row while this one leaves
							if (row_q != COORD_MAX) begin
								ram_en   = 1'b1;
								ram_addr = {addr_q[FRAME_AW-1:COORD_W], row_q + 1'b1};
								row_next = 1'b1;
							end
						end
						default: begin
							e_last = 1'b1;
						end
					endcase
				end
			end
			B_LAYER: begin
				if (out_free) begin
					emit     = 1'b1;
					e_kind   = KIND_LAYER;
					e_layer  = ROW_W'(1) << scan_q;
					e_last   = 1'b1;
					scan_adv = 1'b1;
				end
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= B_IDLE;
			row_q     <= '0;
			scan_q    <= '0;
			off_q     <= '0;
			fill_q    <= 1'b1;
			valid_q   <= '0;
			m_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (row_start) begin
				row_q <= '0;
			end else if (row_next) begin
				row_q <= row_q + 1'b1;
			end
			if (scan_adv) begin
				scan_q <= scan_q + 1'b1;
			end
			// layer rotation moves the physical base of layer zero
			if (rotate) begin
				off_q <= off_q - 1'b1;
			end
			if (wipe) begin
				valid_q <= '0;
				fill_q  <= wipe_val;
			end else if (mark_valid) begin
				valid_q[addr_q] <= 1'b1;
			end
			if (emit) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load_cmd) begin
			op_q <= head.op;
			x_q  <= head.x;
		end
		if (ram_en && !ram_we) begin
			addr_q <= ram_addr;
		end
		if (emit) begin
			m_data_q <= {7'd0, e_voxel, e_layer, e_latch, e_row};
			m_user_q <= e_kind;
			m_last_q <= e_last;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tuser  = m_user_q;
	assign m_tlast  = m_last_q;

	`ASSERT_RST(a_layer_row7, (state_q == B_LAYER) |-> (row_q == COORD_MAX), "early layer beat")
	`ASSERT_RST(a_latch_mid, (m_valid_q && m_user_q == KIND_LATCH) |-> !m_last_q, "latch beat last")
	`ASSERT_RST(a_scan, (state_q == B_LAYER && out_free) |=> scan_q == $past(scan_q) + 3'd1, "no step")

endmodule

`default_nettype wire

>>> rtl/led_cube_frame_buffer_scanner.sv
// top level of the led cube frame buffer scanner
//
//  channel  dir  handshake          payload
//  s_*      in   s_tvalid/s_tready  tuser action, tdata x y z
//  m_*      out  m_tvalid/m_tready  tuser kind, tdata row latch layer voxel, tlast
//
// voxel set, clear and read pass through the back end as a frame ram read followed by the
// modify, write and result beat; clear all, fill all and rotate emit from idle directly.
// a refresh tick is one ram read, eight latch beats with the next row read overlapped
// through the single ram port, then the layer enable beat.
// reset leaves the frame all ones at once through per-row valid bits; no clearing pass.
// the command queue lets input beats land while the back end waits on m_tready.
`default_nettype none

module led_cube_frame_buffer_scanner
	import lcfb_pkg::*;
#(
	parameter int QDEPTH = QUEUE_DEPTH
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [S_TDATA_W-1:0] s_tdata,  // x [2:0], y [5:3], z [8:6], zero pad
	input  wire logic [ACTION_W-1:0]  s_tuser,  // action [2:0]
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic      [M_TDATA_W-1:0] m_tdata,  // row_data [7:0], latch_select [15:8],
	                                            // layer_enable [23:16], voxel_bit [24], zero pad
	output logic      [KIND_W-1:0]    m_tuser,  // kind [1:0]
	output logic                      m_tlast   // last
);

	cmd_t head;
	logic head_valid;
	logic head_pop;

	lcfb_front #(
		.DEPTH (QDEPTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.head       (head),
		.head_valid (head_valid),
		.head_pop   (head_pop)
	);

	lcfb_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (head_valid),
		.head_pop   (head_pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast)
	);

endmodule

`default_nettype wire

>>> tb/led_cube_frame_buffer_scanner_tb.sv
// self-checking testbench for the led cube frame buffer scanner
`default_nettype none

module led_cube_frame_buffer_scanner_tb;
	import lcfb_pkg::*;

	localparam int CYCLE_LIMIT   = 200000;
	localparam int RANDOM_ITEMS  = 300;
	localparam int REPORT_LIMIT  = 10;

	// column latch strobes in latch order
	localparam logic [ROW_W-1:0] STROBE_ORDER [8] = '{
		8'h01, 8'h02, 8'h04, 8'h08, 8'h80, 8'h40, 8'h20, 8'h10
	};

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [ROW_W-1:0]  row;
		logic [ROW_W-1:0]  latch;
		logic [ROW_W-1:0]  layer;
		logic              voxel;
		logic              last;
	} cube_beat_t;

	// typed rows carry the row byte of every latch beat or the read answer
	typedef struct packed {
		op_t                op;
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] z;
		logic               typed;
		logic [ROW_W-1:0]   row_v;
		logic               voxel_v;
	} plan_row_t;

	localparam int PLAN_LEN = 25;
	localparam plan_row_t PLAN [PLAN_LEN] = '{
		'{OP_READ,      3'd0, 3'd0, 3'd0, 1'b1, 8'h00, 1'b1},
		'{OP_READ,      3'd7, 3'd7, 3'd7, 1'b1, 8'h00, 1'b1},
		'{OP_REFRESH,   3'd0, 3'd0, 3'd0, 1'b1, 8'hff, 1'b0},
		'{OP_CLR,       3'd7, 3'd7, 3'd7, 1'b0, 8'h00, 1'b0},
		'{OP_READ,      3'd7, 3'd7, 3'd7, 1'b1, 8'h00, 1'b0},
		'{OP_CLEAR_ALL, 3'd5, 3'd1, 3'd6, 1'b0, 8'h00, 1'b0},
		'{OP_REFRESH,   3'd7, 3'd7, 3'd7, 1'b1, 8'h00, 1'b0},
		'{OP_SET,       3'd7, 3'd7, 3'd7, 1'b0, 8'h00, 1'b0},
		'{OP_SET,       3'd0, 3'd0, 3'd0, 1'b0, 8'h00, 1'b0},
		'{OP_SET,       3'd5, 3'd2, 3'd6, 1'b0, 8'h00, 1'b0},
		'{OP_ROTATE,    3'd0, 3'd0, 3'd0, 1'b0, 8'h00, 1'b0},
		'{OP_READ,      3'd7, 3'd7, 3'd0, 1'b0, 8'h00, 1'b0},
		'{OP_READ,      3'd0, 3'd0, 3'd1, 1'b0, 8'h00, 1'b0},
		'{OP_READ,      3'd5, 3'd2, 3'd7, 1'b0, 8'h00, 1'b0},
		'{OP_READ,      3'd7, 3'd7, 3'd7, 1'b0, 8'h00, 1'b0},
		'{OP_CLR,       3'd0, 3'd0, 3'd1, 1'b0, 8'h00, 1'b0},
		'{OP_READ,      3'd0, 3'd0, 3'd1, 1'b0, 8'h00, 1'b0},
		'{OP_NOP,       3'd7, 3'd7, 3'd7, 1'b1, 8'h00, 1'b0},
		'{OP_REFRESH,   3'd0, 3'd0, 3'd0, 1'b0, 8'h00, 1'b0},
		'{OP_FILL_ALL,  3'd2, 3'd6, 3'd3, 1'b0, 8'h00, 1'b0},
		'{OP_CLR,       3'd3, 3'd4, 3'd0, 1'b0, 8'h00, 1'b0},
		'{OP_ROTATE,    3'd7, 3'd7, 3'd7, 1'b0, 8'h00, 1'b0},
		'{OP_REFRESH,   3'd0, 3'd0, 3'd0, 1'b0, 8'h00, 1'b0},
		'{OP_READ,      3'd3, 3'd4, 3'd1, 1'b0, 8'h00, 1'b0},
		'{OP_SET,       3'd3, 3'd4, 3'd1, 1'b0, 8'h00, 1'b0}
	};

	logic                 clk      = 1'b0;
	logic                 arst_n   = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata  = '0;
	logic [ACTION_W-1:0]  s_tuser  = '0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;
	logic [KIND_W-1:0]    m_tuser;
	logic                 m_tlast;

	led_cube_frame_buffer_scanner dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always #5 clk = ~clk;

	// shadow copy of the frame and scan layer, reset values
	logic [ROW_W-1:0]   shadow_frame [FRAME_DEPTH] = '{default: 8'hff};
	logic [COORD_W-1:0] shadow_layer = '0;

	cube_beat_t pending_beats [$];
	cube_beat_t step_beats [9];
	int         step_count;

	int  cycle_count  = 0;
	int  error_count  = 0;
	int  beats_seen   = 0;
	int  items_sent   = 0;
	int  refresh_seen = 0;
	int  read_seen    = 0;
	logic quiet_run   = 1'b0;

	always @(posedge clk) cycle_count <= cycle_count + 1;

	// results the block should give for one accepted action, state updated
	function automatic void predict_action(input op_t op, input logic [COORD_W-1:0] cx,
			input logic [COORD_W-1:0] cy, input logic [COORD_W-1:0] cz);
		logic [FRAME_AW-1:0] row_idx;
		logic [ROW_W-1:0]    top_layer [8];
		int                  i;
		row_idx = {cz, cy};
		step_count = 1;
		step_beats[0] = '{KIND_ACK, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1};
		case (op)
			OP_SET: shadow_frame[row_idx] = shadow_frame[row_idx] | (8'h01 << cx);
			OP_CLR: shadow_frame[row_idx] = shadow_frame[row_idx] & ~(8'h01 << cx);
			OP_READ: begin
				step_beats[0].voxel = shadow_frame[row_idx][cx];
				read_seen++;
			end
			OP_CLEAR_ALL: for (i = 0; i < FRAME_DEPTH; i++) shadow_frame[i] = 8'h00;
			OP_FILL_ALL:  for (i = 0; i < FRAME_DEPTH; i++) shadow_frame[i] = 8'hff;
			OP_ROTATE: begin
				// layer z takes layer z-1, layer 0 takes the old top layer
				for (i = 0; i < 8; i++) top_layer[i] = shadow_frame[56 + i];
				for (i = FRAME_DEPTH - 1; i >= 8; i--) shadow_frame[i] = shadow_frame[i - 8];
				for (i = 0; i < 8; i++) shadow_frame[i] = top_layer[i];
			end
			OP_REFRESH: begin
				for (i = 0; i < 8; i++)
					step_beats[i] = '{KIND_LATCH, shadow_frame[{shadow_layer, i[2:0]}],
						STROBE_ORDER[i], 8'h00, 1'b0, 1'b0};
				step_beats[8] = '{KIND_LAYER, 8'h00, 8'h00, 8'h01 << shadow_layer, 1'b0, 1'b1};
				step_count = 9;
				shadow_layer = shadow_layer + 3'd1;
				refresh_seen++;
			end
			default: ;
		endcase
	endfunction

	task automatic send_cmd(input op_t op, input logic [COORD_W-1:0] cx,
			input logic [COORD_W-1:0] cy, input logic [COORD_W-1:0] cz,
			input logic typed, input logic [ROW_W-1:0] row_v, input logic voxel_v);
		int i;
		while (!quiet_run && $urandom_range(99) < 17) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {{(S_TDATA_W - 3 * COORD_W){1'b0}}, cz, cy, cx};
		do @(posedge clk); while (!s_tready);
		predict_action(op, cx, cy, cz);
		for (i = 0; i < step_count; i++) begin
			if (typed) begin
				if (step_beats[i].kind == KIND_LATCH)
					step_beats[i].row = row_v;
				else if (step_beats[i].kind == KIND_ACK)
					step_beats[i].voxel = voxel_v;
			end
			pending_beats.push_back(step_beats[i]);
		end
		items_sent++;
	endtask

	// hold the sender off until every expected beat is out
	task automatic wait_for_drain();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending_beats.size() != 0);
	endtask

	task automatic note_error(input string what);
		error_count++;
		if (error_count <= REPORT_LIMIT)
			$display("mismatch at cycle %0d: %s", cycle_count, what);
	endtask

	always @(posedge clk) begin
		m_tready <= quiet_run || ($urandom_range(99) >= 17);
	end

	always @(posedge clk) begin : beat_monitor
		cube_beat_t want;
		if (arst_n && m_tvalid && m_tready) begin
			beats_seen++;
			if (pending_beats.size() == 0) begin
				note_error($sformatf("unexpected beat kind %0d tdata %h last %0d",
					m_tuser, m_tdata, m_tlast));
			end else begin
				want = pending_beats.pop_front();
				if (m_tuser !== want.kind || m_tdata[7:0] !== want.row
						|| m_tdata[15:8] !== want.latch || m_tdata[23:16] !== want.layer
						|| m_tdata[24] !== want.voxel || m_tlast !== want.last)
					note_error($sformatf({"expected kind %0d row %h latch %h layer %h voxel %0d ",
						"last %0d, got kind %0d row %h latch %h layer %h voxel %0d last %0d"},
						want.kind, want.row, want.latch, want.layer, want.voxel, want.last,
						m_tuser, m_tdata[7:0], m_tdata[15:8], m_tdata[23:16], m_tdata[24],
						m_tlast));
			end
		end
	end

	initial begin : watchdog
		wait (cycle_count >= CYCLE_LIMIT);
		$display("FAILED: results differ");
		$finish;
	end

	initial begin : stimulus
		int   n;
		int   pick;
		op_t  op;
		repeat (12) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;
		@(posedge clk);

		for (n = 0; n < PLAN_LEN; n++)
			send_cmd(PLAN[n].op, PLAN[n].x, PLAN[n].y, PLAN[n].z,
				PLAN[n].typed, PLAN[n].row_v, PLAN[n].voxel_v);
		wait_for_drain();

		for (n = 0; n < RANDOM_ITEMS; n++) begin
			// a stretch with both sides always ready
			quiet_run = (n >= 100 && n < 180);
			if (n == 220)
				wait_for_drain();
			pick = $urandom_range(99);
			if (pick < 20)      op = OP_SET;
			else if (pick < 35) op = OP_CLR;
			else if (pick < 55) op = OP_READ;
			else if (pick < 57) op = OP_CLEAR_ALL;
			else if (pick < 60) op = OP_FILL_ALL;
			else if (pick < 65) op = OP_ROTATE;
			else if (pick < 94) op = OP_REFRESH;
			else                op = OP_NOP;
			send_cmd(op, 3'($urandom_range(7)), 3'($urandom_range(7)), 3'($urandom_range(7)),
				1'b0, 8'h00, 1'b0);
		end
		quiet_run = 1'b0;

		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending_beats.size() != 0);
		repeat (16) @(posedge clk);

		$display("drove %0d actions, %0d refresh ticks and %0d voxel reads among them",
			items_sent, refresh_seen, read_seen);
		$display("checked %0d result beats, %0d mismatches", beats_seen, error_count);
		if (error_count == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

`default_nettype wire
